FILE: rtl/core/gwwl_pkg.sv
package gwwl_pkg;

    // Default caps on the line length (the look-ahead window holds one more) and on the line count.
    localparam int DEF_LINE_CHARS_CAP = 16;
    localparam int DEF_LINE_COUNT_CAP = 4;

    // The blank character that lines break at.
    localparam logic [7:0] SPACE_CODE = 8'h20;

    // Configuration port geometry.
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 1;

    // Register reset values.
    localparam logic [4:0] LINE_WIDTH_RESET = 5'd16;
    localparam logic [2:0] LINE_LIMIT_RESET = 3'd4;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_WIDTH = 1'b0,
        REG_LINE_LIMIT = 1'b1
    } cfg_reg_t;

endpackage

FILE: rtl/core/greedy_word_wrap_lines.sv
// Greedy word wrap: characters enter one word at a time and leave as words
// tagged with line and column, at most line_limit lines of at most line_width
// characters per message (each clamped to the range 1 to its cap). The
// look-ahead window is a small memory of LINE_CHARS_CAP+1 characters addressed
// as a ring, with a blank flag per entry for the break search. Each input word
// is accepted and then checked for a complete line; every line placed passes
// through break search, then blank trimming, and every character placed
// through a memory read, then a load into the output register, which waits
// while the output side stalls. A message end that places nothing sends a
// done marker. The input is taken again while the last result still waits in
// the output register.
module greedy_word_wrap_lines #(
    parameter int LINE_CHARS_CAP = gwwl_pkg::DEF_LINE_CHARS_CAP,
    parameter int LINE_COUNT_CAP = gwwl_pkg::DEF_LINE_COUNT_CAP
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [gwwl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gwwl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic [7:0]                     char_code,
    input  logic                           end_of_message,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [7:0]                     out_char,
    output logic [1:0]                     line_index,
    output logic [3:0]                     column,
    output logic                           char_valid,
    output logic                           end_of_line,
    output logic                           message_done
);
    import gwwl_pkg::*;

    localparam int DEPTH = LINE_CHARS_CAP + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int LW    = $clog2(LINE_COUNT_CAP + 1);
    localparam int CW    = (FW > 5) ? FW : 5;
    localparam int KW    = (LW > 3) ? LW : 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_TRIM,
        ST_READ,
        ST_LOAD,
        ST_MARK
    } state_t;

    state_t        state_reg;
    logic [4:0]    line_width_reg;
    logic [2:0]    line_limit_reg;
    logic [IW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic [LW-1:0] lines_reg;
    logic          skip_reg;
    logic          eom_reg;
    logic          any_reg;
    logic [IW-1:0] line_start_reg;
    logic [IW-1:0] take_reg;
    logic [IW-1:0] col_reg;
    logic [LW-1:0] cur_line_reg;
    logic          last_line_reg;

    logic          res_valid_reg;
    logic [7:0]    out_char_reg;
    logic [1:0]    line_index_reg;
    logic [3:0]    column_reg;
    logic          char_valid_reg;
    logic          end_of_line_reg;
    logic          message_done_reg;

    logic [CW-1:0] width_raw;
    logic [KW-1:0] limit_raw;
    logic [FW-1:0] eff_width;
    logic [LW-1:0] eff_limit;
    logic          accept;
    logic          below_limit;
    logic          append;
    logic [IW-1:0] tail;
    logic [IW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [DEPTH-1:0] space_rot;
    logic [IW-1:0] brk;
    logic [FW-1:0] lead;
    logic          place_wide;
    logic          place_flush;
    logic [IW-1:0] take_sel;
    logic [FW-1:0] fill_trim;
    logic [LW-1:0] lines_next;
    logic          slot_free;
    logic          load_out;
    logic          col_last;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                               input logic [FW-1:0] b);
        logic [FW:0] s;
        s = (FW+1)'(a) + (FW+1)'(b);
        if (s >= (FW+1)'(DEPTH))
        begin
            s = s - (FW+1)'(DEPTH);
        end
        return IW'(s);
    endfunction

    // Clamp the registers into the supported range.
    always_comb
    begin
        width_raw = CW'(line_width_reg);
        limit_raw = KW'(line_limit_reg);
        if (width_raw == '0)
        begin
            eff_width = FW'(1);
        end
        else if (width_raw > CW'(LINE_CHARS_CAP))
        begin
            eff_width = FW'(LINE_CHARS_CAP);
        end
        else
        begin
            eff_width = FW'(width_raw);
        end
        if (limit_raw == '0)
        begin
            eff_limit = LW'(1);
        end
        else if (limit_raw > KW'(LINE_COUNT_CAP))
        begin
            eff_limit = LW'(LINE_COUNT_CAP);
        end
        else
        begin
            eff_limit = LW'(limit_raw);
        end
    end

    // Input side and window write.
    always_comb
    begin
        item_ready  = (state_reg == ST_IDLE);
        accept      = item_valid && item_ready;
        below_limit = (lines_reg < eff_limit);
        append      = accept && below_limit
                      && !(skip_reg && (char_code == SPACE_CODE))
                      && (fill_reg < FW'(DEPTH));
        tail        = wrap_add(head_reg, fill_reg);
        rd_addr     = wrap_add(line_start_reg, FW'(col_reg));
    end

    // Line decisions.
    always_comb
    begin
        place_wide  = below_limit && (fill_reg > eff_width);
        place_flush = below_limit && eom_reg && (fill_reg != '0);
        take_sel    = place_wide ? brk : IW'(fill_reg);
        fill_trim   = fill_reg - lead;
        lines_next  = lines_reg + LW'(1);
        slot_free   = !res_valid_reg || result_ready;
        load_out    = slot_free && ((state_reg == ST_LOAD) || (state_reg == ST_MARK));
        col_last    = (col_reg == IW'(take_reg - IW'(1)));
    end

    gwwl_window #(
        .DEPTH (DEPTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (append),
        .wr_addr   (tail),
        .wr_data   (char_code),
        .rd_en     (state_reg == ST_READ),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .head      (head_reg),
        .space_rot (space_rot)
    );

    gwwl_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .space_rot (space_rot),
        .width     (eff_width),
        .fill      (fill_reg),
        .brk       (brk),
        .lead      (lead)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            line_limit_reg <= LINE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LINE_WIDTH: line_width_reg <= cfg_data[4:0];
                REG_LINE_LIMIT: line_limit_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            lines_reg      <= '0;
            skip_reg       <= 1'b0;
            eom_reg        <= 1'b0;
            any_reg        <= 1'b0;
            line_start_reg <= '0;
            take_reg       <= '0;
            col_reg        <= '0;
            cur_line_reg   <= '0;
            last_line_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            // The output word leaves when taken, unless a new one is loaded.
            if (res_valid_reg && result_ready && !load_out)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        eom_reg <= end_of_message;
                        any_reg <= 1'b0;
                        if (below_limit && !(skip_reg && (char_code == SPACE_CODE)))
                        begin
                            skip_reg <= 1'b0;
                        end
                        if (append)
                        begin
                            fill_reg <= fill_reg + FW'(1);
                        end
                        state_reg <= ST_SEARCH;
                    end
                end

                ST_SEARCH:
                begin
                    if (place_wide || place_flush)
                    begin
                        line_start_reg <= head_reg;
                        take_reg       <= take_sel;
                        head_reg       <= wrap_add(head_reg, FW'(take_sel));
                        fill_reg       <= fill_reg - FW'(take_sel);
                        cur_line_reg   <= lines_reg;
                        state_reg      <= ST_TRIM;
                    end
                    else if (eom_reg)
                    begin
                        fill_reg  <= '0;
                        lines_reg <= '0;
                        skip_reg  <= 1'b0;
                        state_reg <= any_reg ? ST_IDLE : ST_MARK;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_TRIM:
                begin
                    // Drop the blanks after the break and close the line.
                    head_reg      <= wrap_add(head_reg, lead);
                    lines_reg     <= lines_next;
                    skip_reg      <= (fill_trim == '0);
                    fill_reg      <= (lines_next >= eff_limit) ? '0 : fill_trim;
                    last_line_reg <= eom_reg
                                     && !((lines_next < eff_limit) && (fill_trim != '0));
                    col_reg       <= '0;
                    state_reg     <= ST_READ;
                end

                ST_READ:
                begin
                    state_reg <= ST_LOAD;
                end

                ST_LOAD:
                begin
                    if (slot_free)
                    begin
                        res_valid_reg    <= 1'b1;
                        out_char_reg     <= rd_data;
                        line_index_reg   <= 2'(cur_line_reg);
                        column_reg       <= 4'(col_reg);
                        char_valid_reg   <= 1'b1;
                        end_of_line_reg  <= col_last;
                        message_done_reg <= col_last && last_line_reg;
                        any_reg          <= 1'b1;
                        if (col_last)
                        begin
                            state_reg <= ST_SEARCH;
                        end
                        else
                        begin
                            col_reg   <= col_reg + IW'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end

                ST_MARK:
                begin
                    // Message ended with nothing placed: send a done marker.
                    if (slot_free)
                    begin
                        res_valid_reg    <= 1'b1;
                        out_char_reg     <= '0;
                        line_index_reg   <= '0;
                        column_reg       <= '0;
                        char_valid_reg   <= 1'b0;
                        end_of_line_reg  <= 1'b0;
                        message_done_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = res_valid_reg;
    assign out_char     = out_char_reg;
    assign line_index   = line_index_reg;
    assign column       = column_reg;
    assign char_valid   = char_valid_reg;
    assign end_of_line  = end_of_line_reg;
    assign message_done = message_done_reg;

endmodule

FILE: rtl/core/gwwl_window.sv
module gwwl_window #(
    parameter int DEPTH = 17
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [7:0]                 rd_data,
    input  logic [$clog2(DEPTH)-1:0]   head,
    output logic [DEPTH-1:0]           space_rot
);
    import gwwl_pkg::*;

    logic [7:0]         mem [DEPTH];
    logic [7:0]         rd_data_reg;
    logic [DEPTH-1:0]   space_flag_reg;
    logic [2*DEPTH-1:0] flag_shift;

    // Character store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // One blank flag per entry, kept beside the store so the break search
    // can look at the whole window at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_flag_reg <= '0;
        end
        else if (wr_en)
        begin
            space_flag_reg[wr_addr] <= (wr_data == SPACE_CODE);
        end
    end

    // Rotate the flags so that bit 0 is the oldest character in the window.
    always_comb
    begin
        flag_shift = {space_flag_reg, space_flag_reg} >> head;
        space_rot  = flag_shift[DEPTH-1:0];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/gwwl_scan.sv
module gwwl_scan #(
    parameter int DEPTH = 17
) (
    input  logic [DEPTH-1:0]             space_rot,
    input  logic [$clog2(DEPTH+1)-1:0]   width,
    input  logic [$clog2(DEPTH+1)-1:0]   fill,
    output logic [$clog2(DEPTH)-1:0]     brk,
    output logic [$clog2(DEPTH+1)-1:0]   lead
);
    localparam int IW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH+1);

    // Break point: the last blank at positions 1 to width, else a hard cut.
    always_comb
    begin
        brk = IW'(width);
        for (int p = 1; p < DEPTH; p++)
        begin
            if ((FW'(p) <= width) && space_rot[p])
            begin
                brk = IW'(p);
            end
        end
    end

    // Leading blanks: position of the first filled non-blank character.
    always_comb
    begin
        lead = FW'(DEPTH);
        for (int p = DEPTH - 1; p >= 0; p--)
        begin
            if (!((FW'(p) < fill) && space_rot[p]))
            begin
                lead = FW'(p);
            end
        end
    end

endmodule
